[hdl/json_strict_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef JSON_STRICT_TOKENIZER_DEFINES_SVH
`define JSON_STRICT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define JST_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while in reset.
`define JST_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tokenizer assertion failed");

`endif

[hdl/jst_pkg.sv]
// ----------------------------------------------------------------------------
// jst_pkg
// Types, character codes and helpers for the strict JSON tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int DEFAULT_POOL_DEPTH    = 64;
  localparam int DEFAULT_POSITION_BITS = 16;

  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [5:0] KIDS_MAX   = 6'd63;
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'd48;
  localparam logic [7:0] CH_9      = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_F   = 8'd70;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'd102;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_MAX_PRINT = 8'd126;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_BUMP_RD, ST_BUMP_WR, ST_IDLE_BYTE, ST_OPEN_CHK,
    ST_OPEN_WR, ST_CLOSE_RD, ST_CLOSE_CHK, ST_AFTER_RD, ST_AFTER_CHK,
    ST_COMMA_CHK, ST_COMMA_RD, ST_COMMA_CHK2, ST_PRIM_CHK, ST_FINISH, ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_STR, MODE_ESC, MODE_HEX, MODE_PRIM
  } mode_e;

  typedef enum logic [1:0] {TYPE_OBJ, TYPE_ARR, TYPE_STR, TYPE_PRIM} tok_type_e;

  typedef enum logic [1:0] {
    STAT_OK, STAT_INVALID, STAT_PARTIAL, STAT_EXHAUSTED
  } status_e;

  typedef enum logic [2:0] {
    CLS_OPEN, CLS_CLOSE, CLS_QUOTE, CLS_SPACE, CLS_COLON, CLS_COMMA, CLS_PRIM,
    CLS_BAD
  } byte_cls_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       doc_start;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  token_index;
    logic [1:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [5:0]  child_count;
    logic        token_done;
    logic [1:0]  status;
    logic        last_result;
  } out_t;

  function automatic byte_cls_e classify(logic [7:0] c);
    byte_cls_e k;
    if (c == CH_LBRACE || c == CH_LBRACK) k = CLS_OPEN;
    else if (c == CH_RBRACE || c == CH_RBRACK) k = CLS_CLOSE;
    else if (c == CH_QUOTE) k = CLS_QUOTE;
    else if (c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE) k = CLS_SPACE;
    else if (c == CH_COLON) k = CLS_COLON;
    else if (c == CH_COMMA) k = CLS_COMMA;
    else if ((c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_LO_T ||
             c == CH_LO_F || c == CH_LO_N) k = CLS_PRIM;
    else k = CLS_BAD;
    return k;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UP_A && c <= CH_UP_F) ||
           (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  function automatic logic ends_prim(logic [7:0] c);
    return c == CH_COLON || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_SPACE || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE;
  endfunction

  function automatic logic esc_ok(logic [7:0] c);
    return c == CH_QUOTE || c == CH_SLASH || c == CH_BSLASH || c == CH_LO_B ||
           c == CH_LO_F || c == CH_LO_R || c == CH_LO_N || c == CH_LO_T;
  endfunction

endpackage

[hdl/json_strict_tokenizer.sv]
// ----------------------------------------------------------------------------
// json_strict_tokenizer
// Byte-serial strict JSON tokenizer building a token table in local memory.
// ----------------------------------------------------------------------------
// One byte is taken when start is high and busy is low; busy then stays high
// until all results of that byte are out. A byte in a closed document is
// dropped. A leaf that ends (a closing quote, or a primitive's ending byte)
// is written to the token table and bumps its parent's child count; a
// primitive's ending byte is then handled as a byte between tokens. Opening
// a container under a parent first reads that parent and bumps its child
// count. A closing bracket, or a comma after a key, scans the token table
// back one record at a time through the single read port, so one byte may
// visit up to POOL_DEPTH records. Each result is on result_o for one cycle
// with result_valid_o high; the receiver cannot stall, so take them as they
// come. The limit register is written only while busy is low. No clearing
// pass after reset.
`include "json_strict_tokenizer_defines.svh"

module json_strict_tokenizer #(
  parameter int POOL_DEPTH    = jst_pkg::DEFAULT_POOL_DEPTH,
  parameter int POSITION_BITS = jst_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  jst_pkg::in_t                 item_i,
  output logic                         result_valid_o,
  output jst_pkg::out_t                result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jst_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import jst_pkg::*;

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam int PB = POSITION_BITS;
  localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef struct packed {
    logic          done;
    logic [5:0]    kids;
    logic [PB-1:0] len;
    logic [PB-1:0] start;
    logic [1:0]    ttype;
  } rec_t;

  rec_t mem [POOL_DEPTH];
  rec_t rdata_q, wdata;
  logic [IW-1:0] raddr, waddr;
  logic we;

  state_e state_q, state_d, cont_q, cont_d;
  in_t in_q, in_d;
  logic [CW-1:0] count_q, count_d, open_q, open_d, parent_q, parent_d, scan_q, scan_d;
  logic [PB-1:0] pos_q, pos_d, pstart_q, pstart_d;
  mode_e mode_q, mode_d;
  logic [2:0] hex_q, hex_d;
  logic closed_q, closed_d, nul_q, nul_d, sset_q, sset_d;
  status_e stat_q, stat_d;
  logic [LIMIT_W-1:0] limit_q;
  logic pend_v_q, pend_v_d, res_v_q, res_v_d;
  out_t pend_q, pend_d, res_q, res_d;

  logic emit;
  out_t emit_res;
  logic [7:0] c;
  byte_cls_e cls;
  logic room, parent_none, leaf_req;
  logic [CW-1:0] scan_m1, count_p1;
  tok_type_e want;

  function automatic out_t rec_result(logic [IW-1:0] slot, rec_t r);
    logic [31:0] s32, st32, ln32;
    out_t o;
    s32  = 32'(slot);
    st32 = 32'(r.start);
    ln32 = 32'(r.len);
    o = '0;
    o.token_index  = s32[5:0];
    o.token_type   = r.ttype;
    o.token_start  = st32[15:0];
    o.token_length = ln32[15:0];
    o.child_count  = r.kids;
    o.token_done   = r.done;
    return o;
  endfunction

  function automatic out_t stat_result(status_e s);
    out_t o;
    o = '0;
    o.result_kind = 1'b1;
    o.status = s;
    return o;
  endfunction

  assign c           = in_q.data_byte;
  assign cls         = classify(c);
  assign parent_none = &parent_q;
  assign room        = (MW'(count_q) < MW'(limit_q)) && (count_q < CW'(POOL_DEPTH));
  assign scan_m1     = scan_q - CW'(1);
  assign count_p1    = count_q + CW'(1);
  assign leaf_req    = (mode_q == MODE_STR && c == CH_QUOTE) ||
                       (mode_q == MODE_PRIM && ends_prim(c));
  assign want        = (c == CH_RBRACE) ? TYPE_OBJ : TYPE_ARR;

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // Token table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    unique case (state_q)
      ST_CLOSE_RD, ST_AFTER_RD, ST_COMMA_RD: raddr = scan_m1[IW-1:0];
      default:                               raddr = parent_q[IW-1:0];
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_DECODE;
      ST_DECODE: begin
        if (closed_q) state_d = ST_IDLE;
        else if (leaf_req) begin
          if (!room) state_d = ST_FINISH;
          else if (parent_q < count_p1) state_d = ST_BUMP_RD;
          else if (mode_q == MODE_PRIM) state_d = ST_IDLE_BYTE;
          else state_d = ST_FINISH;
        end else if (mode_q != MODE_STR && mode_q != MODE_ESC && mode_q != MODE_HEX &&
                     mode_q != MODE_PRIM && c != CH_NUL) state_d = ST_IDLE_BYTE;
        else state_d = ST_FINISH;
      end
      ST_BUMP_RD: state_d = ST_BUMP_WR;
      ST_BUMP_WR: state_d = cont_q;
      ST_IDLE_BYTE: begin
        unique case (cls)
          CLS_OPEN:  state_d = !room ? ST_FINISH : (parent_none ? ST_OPEN_WR : ST_OPEN_CHK);
          CLS_CLOSE: state_d = parent_none ? ST_FINISH : ST_CLOSE_RD;
          CLS_COMMA: state_d = parent_none ? ST_FINISH : ST_COMMA_CHK;
          CLS_PRIM:  state_d = parent_none ? ST_FINISH : ST_PRIM_CHK;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_OPEN_CHK: begin
        if (rdata_q.ttype == TYPE_OBJ) state_d = ST_FINISH;
        else if (parent_q < count_q) state_d = ST_BUMP_WR;
        else state_d = ST_OPEN_WR;
      end
      ST_OPEN_WR:  state_d = ST_FINISH;
      ST_CLOSE_RD: state_d = (scan_q == '0) ? ST_FINISH : ST_CLOSE_CHK;
      ST_CLOSE_CHK: begin
        if (rdata_q.done) state_d = ST_CLOSE_RD;
        else if (rdata_q.ttype != want) state_d = ST_FINISH;
        else state_d = ST_AFTER_RD;
      end
      ST_AFTER_RD:  state_d = (scan_q == '0) ? ST_FINISH : ST_AFTER_CHK;
      ST_AFTER_CHK: state_d = rdata_q.done ? ST_AFTER_RD : ST_FINISH;
      ST_COMMA_CHK: begin
        if (rdata_q.ttype == TYPE_ARR || rdata_q.ttype == TYPE_OBJ) state_d = ST_FINISH;
        else state_d = ST_COMMA_RD;
      end
      ST_COMMA_RD: state_d = (scan_q == '0) ? ST_FINISH : ST_COMMA_CHK2;
      ST_COMMA_CHK2: begin
        if ((rdata_q.ttype == TYPE_ARR || rdata_q.ttype == TYPE_OBJ) && !rdata_q.done)
          state_d = ST_FINISH;
        else state_d = ST_COMMA_RD;
      end
      ST_PRIM_CHK: state_d = ST_FINISH;
      ST_FINISH:   state_d = ST_FLUSH;
      ST_FLUSH:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and result sequencing.
  always_comb begin
    cont_d   = cont_q;
    in_d     = in_q;
    count_d  = count_q;
    open_d   = open_q;
    parent_d = parent_q;
    scan_d   = scan_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    mode_d   = mode_q;
    hex_d    = hex_q;
    closed_d = closed_q;
    nul_d    = nul_q;
    sset_d   = sset_q;
    stat_d   = stat_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = count_q[IW-1:0];
    wdata    = rdata_q;
    emit     = 1'b0;
    emit_res = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          in_d   = item_i;
          nul_d  = 1'b0;
          sset_d = 1'b0;
          if (item_i.doc_start) begin
            count_d  = '0;
            open_d   = '0;
            parent_d = '1;
            pos_d    = '0;
            pstart_d = '0;
            mode_d   = MODE_IDLE;
            hex_d    = '0;
            closed_d = 1'b0;
          end
        end
      end
      ST_DECODE: begin
        if (!closed_q) begin
          if (leaf_req) begin
            if (!room) begin
              sset_d = 1'b1;
              stat_d = STAT_EXHAUSTED;
            end else begin
              we          = 1'b1;
              wdata.ttype = (mode_q == MODE_STR) ? TYPE_STR : TYPE_PRIM;
              wdata.start = pstart_q;
              wdata.len   = pos_q - pstart_q;
              wdata.kids  = '0;
              wdata.done  = 1'b1;
              emit        = 1'b1;
              emit_res    = rec_result(count_q[IW-1:0], wdata);
              count_d     = count_p1;
              mode_d      = MODE_IDLE;
              cont_d      = (mode_q == MODE_PRIM) ? ST_IDLE_BYTE : ST_FINISH;
            end
          end else begin
            unique case (mode_q)
              MODE_STR: begin
                if (c == CH_NUL) nul_d = 1'b1;
                else if (c == CH_BSLASH) mode_d = MODE_ESC;
              end
              MODE_ESC: begin
                if (esc_ok(c)) mode_d = MODE_STR;
                else if (c == CH_LO_U) begin
                  mode_d = MODE_HEX;
                  hex_d  = HEX_DIGITS;
                end else begin
                  sset_d = 1'b1;
                  stat_d = STAT_INVALID;
                end
              end
              MODE_HEX: begin
                if (c == CH_NUL) nul_d = 1'b1;
                else if (!is_hex(c)) begin
                  sset_d = 1'b1;
                  stat_d = STAT_INVALID;
                end else begin
                  hex_d = (hex_q != '0) ? hex_q - 3'd1 : hex_q;
                  if (hex_d == '0) mode_d = MODE_STR;
                end
              end
              MODE_PRIM: begin
                if (c == CH_NUL) nul_d = 1'b1;
                else if (c < CH_SPACE || c > CH_MAX_PRINT) begin
                  sset_d = 1'b1;
                  stat_d = STAT_INVALID;
                end
              end
              default: begin
                mode_d = MODE_IDLE;
                if (c == CH_NUL) nul_d = 1'b1;
              end
            endcase
          end
        end
      end
      ST_BUMP_WR: begin
        we         = 1'b1;
        waddr      = parent_q[IW-1:0];
        wdata.kids = (rdata_q.kids == KIDS_MAX) ? KIDS_MAX : rdata_q.kids + 6'd1;
        emit       = 1'b1;
        emit_res   = rec_result(parent_q[IW-1:0], wdata);
      end
      ST_IDLE_BYTE: begin
        unique case (cls)
          CLS_OPEN: begin
            if (!room) begin
              sset_d = 1'b1;
              stat_d = STAT_EXHAUSTED;
            end
          end
          CLS_CLOSE: begin
            if (parent_none) begin
              sset_d = 1'b1;
              stat_d = STAT_INVALID;
            end else scan_d = count_q;
          end
          CLS_QUOTE: begin
            if (parent_none) begin
              sset_d = 1'b1;
              stat_d = STAT_INVALID;
            end else begin
              pstart_d = pos_q + PB'(1);
              mode_d   = MODE_STR;
            end
          end
          CLS_COLON: begin
            if (parent_none) begin
              sset_d = 1'b1;
              stat_d = STAT_INVALID;
            end else parent_d = count_q - CW'(1);
          end
          CLS_PRIM: begin
            if (parent_none) begin
              sset_d = 1'b1;
              stat_d = STAT_INVALID;
            end
          end
          CLS_BAD: begin
            sset_d = 1'b1;
            stat_d = STAT_INVALID;
          end
          default: ;
        endcase
      end
      ST_OPEN_CHK: begin
        if (rdata_q.ttype == TYPE_OBJ) begin
          sset_d = 1'b1;
          stat_d = STAT_INVALID;
        end else cont_d = ST_OPEN_WR;
      end
      ST_OPEN_WR: begin
        we          = 1'b1;
        wdata.ttype = (c == CH_LBRACE) ? TYPE_OBJ : TYPE_ARR;
        wdata.start = pos_q;
        wdata.len   = '0;
        wdata.kids  = '0;
        wdata.done  = 1'b0;
        emit        = 1'b1;
        emit_res    = rec_result(count_q[IW-1:0], wdata);
        count_d     = count_p1;
        parent_d    = count_q;
        open_d      = open_q + CW'(1);
      end
      ST_CLOSE_RD: begin
        if (scan_q == '0) begin
          sset_d = 1'b1;
          stat_d = STAT_INVALID;
        end
      end
      ST_CLOSE_CHK: begin
        if (rdata_q.done) scan_d = scan_m1;
        else if (rdata_q.ttype != want) begin
          sset_d = 1'b1;
          stat_d = STAT_INVALID;
        end else begin
          we         = 1'b1;
          waddr      = scan_m1[IW-1:0];
          wdata.len  = pos_q - rdata_q.start + PB'(1);
          wdata.done = 1'b1;
          emit       = 1'b1;
          emit_res   = rec_result(scan_m1[IW-1:0], wdata);
          open_d     = open_q - CW'(1);
          scan_d     = scan_m1;
        end
      end
      ST_AFTER_RD: begin
        if (scan_q == '0) begin
          parent_d = '1;
          sset_d   = 1'b1;
          stat_d   = STAT_OK;
        end
      end
      ST_AFTER_CHK: begin
        if (rdata_q.done) scan_d = scan_m1;
        else parent_d = scan_m1;
      end
      ST_COMMA_CHK: scan_d = count_q;
      ST_COMMA_CHK2: begin
        if ((rdata_q.ttype == TYPE_ARR || rdata_q.ttype == TYPE_OBJ) && !rdata_q.done)
          parent_d = scan_m1;
        else scan_d = scan_m1;
      end
      ST_PRIM_CHK: begin
        if (rdata_q.ttype == TYPE_OBJ ||
            (rdata_q.ttype == TYPE_STR && rdata_q.kids != '0)) begin
          sset_d = 1'b1;
          stat_d = STAT_INVALID;
        end else begin
          pstart_d = pos_q;
          mode_d   = MODE_PRIM;
        end
      end
      ST_FINISH: begin
        if (sset_q) begin
          emit     = 1'b1;
          emit_res = stat_result(stat_q);
          closed_d = 1'b1;
        end else if (nul_q || in_q.end_of_input) begin
          emit     = 1'b1;
          emit_res = stat_result((mode_q != MODE_IDLE || open_q != '0) ?
                                 STAT_PARTIAL : STAT_OK);
          closed_d = 1'b1;
        end
        pos_d = pos_q + PB'(1);
      end
      ST_FLUSH: begin
        // Last result of the byte goes out with its end mark.
        if (pend_v_q) begin
          res_v_d           = 1'b1;
          res_d             = pend_q;
          res_d.last_result = 1'b1;
          pend_v_d          = 1'b0;
        end
      end
      default: ;
    endcase

    // Hold one result back so the final one can carry last_result.
    if (emit) begin
      if (pend_v_q) begin
        res_v_d = 1'b1;
        res_d   = pend_q;
      end
      pend_d   = emit_res;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cont_q   <= ST_FINISH;
      count_q  <= '0;
      open_q   <= '0;
      parent_q <= '1;
      scan_q   <= '0;
      pos_q    <= '0;
      pstart_q <= '0;
      mode_q   <= MODE_IDLE;
      hex_q    <= '0;
      closed_q <= 1'b0;
      nul_q    <= 1'b0;
      sset_q   <= 1'b0;
      stat_q   <= STAT_OK;
      limit_q  <= LIMIT_RESET;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cont_q   <= cont_d;
      count_q  <= count_d;
      open_q   <= open_d;
      parent_q <= parent_d;
      scan_q   <= scan_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      mode_q   <= mode_d;
      hex_q    <= hex_d;
      closed_q <= closed_d;
      nul_q    <= nul_d;
      sset_q   <= sset_d;
      stat_q   <= stat_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  `JST_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `JST_ASSERT_NOW(a_status_is_last, res_v_q && res_q.result_kind, res_q.last_result)
  `JST_ASSERT_NOW(a_idle_nothing_held, state_q == ST_IDLE, !pend_v_q)
  `JST_ASSERT_NOW(a_open_within_count, state_q != ST_IDLE, open_q <= count_q)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strict JSON tokenizer: directed documents for
// each error and end case, then random well-formed and damaged documents
// under several pool limits, with every token update and status checked
// against a behavioral tokenizer kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
  import jst_pkg::*;

  localparam int DEPTH = 64;
  localparam int KEEP = -1;
  localparam int SETTLE = 320;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t item_i = '0;
  logic result_valid_o;
  out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  json_strict_tokenizer DUT (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Tokenizer state mirror
  tok_type_e   rec_type[DEPTH];
  logic [15:0] rec_start[DEPTH];
  logic [15:0] rec_len[DEPTH];
  logic [5:0]  rec_kids[DEPTH];
  bit          rec_done[DEPTH];
  int          rec_count;
  int          parent;
  logic [15:0] byte_pos;
  mode_e       scan;
  int          hex_left;
  logic [15:0] str_start;
  bit          doc_closed;
  int          pool_limit = 64;

  out_t byte_results[$];
  out_t results_due[$];
  logic [7:0] doc_q[$];
  int errors = 0;
  int sent_bytes = 0;

  function automatic void clear_doc();
    for (int i = 0; i < DEPTH; i++) begin
      rec_type[i] = TYPE_OBJ; rec_start[i] = '0; rec_len[i] = '0;
      rec_kids[i] = '0; rec_done[i] = 1'b0;
    end
    rec_count = 0; parent = -1; byte_pos = '0; scan = MODE_IDLE;
    hex_left = 0; str_start = '0; doc_closed = 1'b0;
  endfunction

  function automatic void emit_rec(int s);
    out_t o;
    if (byte_results.size() >= 4) return;
    o = '0;
    o.token_index = s[5:0]; o.token_type = rec_type[s]; o.token_start = rec_start[s];
    o.token_length = rec_len[s]; o.child_count = rec_kids[s]; o.token_done = rec_done[s];
    byte_results.push_back(o);
  endfunction

  function automatic void emit_status(int s);
    out_t o;
    if (byte_results.size() >= 4) return;
    o = '0;
    o.result_kind = 1'b1;
    o.status = s[1:0];
    byte_results.push_back(o);
  endfunction

  function automatic bit pool_room();
    int lim;
    lim = pool_limit > DEPTH ? DEPTH : pool_limit;
    return rec_count + 1 <= lim;
  endfunction

  function automatic void bump_parent();
    if (parent < 0 || parent >= rec_count) return;
    if (rec_kids[parent] < KIDS_MAX) rec_kids[parent]++;
    emit_rec(parent);
  endfunction

  function automatic int add_leaf(tok_type_e t, logic [15:0] s, logic [15:0] e);
    if (!pool_room()) return int'(STAT_EXHAUSTED);
    rec_type[rec_count] = t; rec_start[rec_count] = s; rec_len[rec_count] = e - s;
    rec_kids[rec_count] = '0; rec_done[rec_count] = 1'b1;
    rec_count++;
    emit_rec(rec_count - 1);
    bump_parent();
    scan = MODE_IDLE;
    return KEEP;
  endfunction

  function automatic int between_tokens(logic [7:0] c, logic [15:0] p);
    int i;
    tok_type_e want;
    if (c == CH_LBRACE || c == CH_LBRACK) begin
      if (!pool_room()) return int'(STAT_EXHAUSTED);
      if (parent >= 0) begin
        if (rec_type[parent] == TYPE_OBJ) return int'(STAT_INVALID);
        bump_parent();
      end
      rec_type[rec_count] = (c == CH_LBRACE) ? TYPE_OBJ : TYPE_ARR;
      rec_start[rec_count] = p; rec_len[rec_count] = '0;
      rec_kids[rec_count] = '0; rec_done[rec_count] = 1'b0;
      rec_count++;
      emit_rec(rec_count - 1);
      parent = rec_count - 1;
      return KEEP;
    end
    if (c == CH_RBRACE || c == CH_RBRACK) begin
      want = (c == CH_RBRACE) ? TYPE_OBJ : TYPE_ARR;
      if (parent < 0) return int'(STAT_INVALID);
      i = rec_count;
      while (i > 0 && rec_done[i-1]) i--;
      if (i == 0) return int'(STAT_INVALID);
      if (rec_type[i-1] != want) return int'(STAT_INVALID);
      rec_len[i-1] = p - rec_start[i-1] + 16'd1;
      rec_done[i-1] = 1'b1;
      emit_rec(i - 1);
      while (i > 0 && rec_done[i-1]) i--;
      if (i == 0) begin
        parent = -1;
        return int'(STAT_OK);
      end
      parent = i - 1;
      return KEEP;
    end
    if (c == CH_QUOTE) begin
      if (parent < 0) return int'(STAT_INVALID);
      str_start = p + 16'd1;
      scan = MODE_STR;
      return KEEP;
    end
    if (c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE) return KEEP;
    if (c == CH_COLON) begin
      if (parent < 0) return int'(STAT_INVALID);
      parent = rec_count - 1;
      return KEEP;
    end
    if (c == CH_COMMA) begin
      if (parent >= 0) begin
        if (rec_type[parent] == TYPE_ARR || rec_type[parent] == TYPE_OBJ) return KEEP;
        for (i = rec_count; i > 0; i--) begin
          if ((rec_type[i-1] == TYPE_ARR || rec_type[i-1] == TYPE_OBJ) && !rec_done[i-1]) begin
            parent = i - 1;
            break;
          end
        end
      end
      return KEEP;
    end
    if ((c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_LO_T || c == CH_LO_F ||
        c == CH_LO_N) begin
      if (parent < 0) return int'(STAT_INVALID);
      if (rec_type[parent] == TYPE_OBJ || (rec_type[parent] == TYPE_STR && rec_kids[parent] != 0))
        return int'(STAT_INVALID);
      str_start = p;
      scan = MODE_PRIM;
      return KEEP;
    end
    return int'(STAT_INVALID);
  endfunction

  function automatic int doc_end_status();
    if (scan != MODE_IDLE) return int'(STAT_PARTIAL);
    for (int i = 0; i < rec_count; i++)
      if (!rec_done[i]) return int'(STAT_PARTIAL);
    return int'(STAT_OK);
  endfunction

  // Advance the mirror by one accepted byte and queue the results it causes.
  function automatic void tokenize_byte(in_t x);
    logic [7:0] c;
    logic [15:0] p;
    int r;
    bit nul;
    out_t o;
    c = x.data_byte; r = KEEP; nul = 1'b0;
    byte_results.delete();
    if (x.doc_start) clear_doc();
    if (doc_closed) return;
    p = byte_pos;
    case (scan)
      MODE_STR: begin
        if (c == CH_NUL) nul = 1'b1;
        else if (c == CH_QUOTE) r = add_leaf(TYPE_STR, str_start, p);
        else if (c == CH_BSLASH) scan = MODE_ESC;
      end
      MODE_ESC: begin
        if (c == CH_QUOTE || c == CH_SLASH || c == CH_BSLASH || c == CH_LO_B ||
            c == CH_LO_F || c == CH_LO_R || c == CH_LO_N || c == CH_LO_T) scan = MODE_STR;
        else if (c == CH_LO_U) begin
          scan = MODE_HEX; hex_left = 4;
        end else r = int'(STAT_INVALID);
      end
      MODE_HEX: begin
        if (c == CH_NUL) nul = 1'b1;
        else if (!((c >= CH_0 && c <= CH_9) || (c >= CH_UP_A && c <= CH_UP_F) ||
                   (c >= CH_LO_A && c <= CH_LO_F))) r = int'(STAT_INVALID);
        else begin
          if (hex_left > 0) hex_left--;
          if (hex_left == 0) scan = MODE_STR;
        end
      end
      MODE_PRIM: begin
        if (c == CH_NUL) nul = 1'b1;
        else if (c == CH_COLON || c == CH_TAB || c == CH_CR || c == CH_LF ||
                 c == CH_SPACE || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE) begin
          r = add_leaf(TYPE_PRIM, str_start, p);
          if (r == KEEP) r = between_tokens(c, p);
        end else if (c < CH_SPACE || c > CH_MAX_PRINT) r = int'(STAT_INVALID);
      end
      default: begin
        scan = MODE_IDLE;
        if (c == CH_NUL) nul = 1'b1;
        else r = between_tokens(c, p);
      end
    endcase
    if (r != KEEP) begin
      emit_status(r); doc_closed = 1'b1;
    end else if (nul || x.end_of_input) begin
      emit_status(doc_end_status()); doc_closed = 1'b1;
    end
    byte_pos = byte_pos + 16'd1;
    if (byte_results.size() > 0) begin
      o = byte_results[$];
      o.last_result = 1'b1;
      byte_results[$] = o;
    end
    foreach (byte_results[k]) results_due.push_back(byte_results[k]);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        errors++;
      end else begin
        if (result_o !== results_due[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, results_due[0], result_o);
          errors++;
        end
        void'(results_due.pop_front());
      end
    end
  end

  task automatic send_byte(in_t x);
    int g;
    start <= 1'b1;
    item_i <= x;
    do @(posedge clk_i); while (busy);
    tokenize_byte(x);
    sent_bytes++;
    if ($urandom_range(0, 9) < 4) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_limit(int v);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_limit = v;
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  // Send doc_q as one document; the end flag rides on the last byte if asked.
  task automatic send_doc(bit end_flag);
    in_t x;
    foreach (doc_q[i]) begin
      x.data_byte = doc_q[i];
      x.doc_start = (i == 0);
      x.end_of_input = end_flag && (i == doc_q.size() - 1);
      send_byte(x);
    end
    doc_q.delete();
  endtask

  task automatic run_text(string s, bit end_flag);
    push_text(s);
    send_doc(end_flag);
  endtask

  function automatic void gen_string();
    string hexd = "0123456789abcdefABCDEF";
    doc_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: push_text("\\n");
        1: begin
          push_text("\\u");
          repeat (4) doc_q.push_back(hexd[$urandom_range(0, 21)]);
        end
        default: doc_q.push_back(8'($urandom_range(32, 126)) == CH_QUOTE ? CH_LO_A :
                                 8'($urandom_range(97, 122)));
      endcase
    end
    doc_q.push_back(CH_QUOTE);
  endfunction

  function automatic void gen_value(int lvl);
    string prims[6] = '{"-12", "0", "true", "null", "f", "7e+3"};
    int k;
    int n;
    k = $urandom_range(0, lvl > 2 ? 1 : 3);
    case (k)
      0: gen_string();
      1: push_text(prims[$urandom_range(0, 5)]);
      2: begin
        doc_q.push_back(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) push_text($urandom_range(0, 3) == 0 ? ", " : ",");
          gen_value(lvl + 1);
        end
        doc_q.push_back(CH_RBRACK);
      end
      default: begin
        doc_q.push_back(CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc_q.push_back(CH_COMMA);
          gen_string();
          doc_q.push_back(CH_COLON);
          gen_value(lvl + 1);
        end
        doc_q.push_back(CH_RBRACE);
      end
    endcase
  endfunction

  task automatic test_directed_docs();
    run_text("{\"k\":[1,-2],\"s\":\"x\\n\\u0aF9\"}", 1'b0);
    run_text("zz", 1'b0);                    // invalid byte, then a byte in the closed document
    run_text("[", 1'b1);                     // partial at end flag
    run_text("\"", 1'b0);                    // string at top level
    push_text("[\"ab"); doc_q.push_back(CH_NUL); send_doc(1'b0);
    push_text("[\"\\"); doc_q.push_back(CH_NUL); send_doc(1'b0);
    push_text("[\"\\u1G"); send_doc(1'b0);
    push_text("[1"); doc_q.push_back(8'h7F); send_doc(1'b0);
    doc_q.push_back(8'hFF); send_doc(1'b0);
    doc_q.push_back(CH_NUL); send_doc(1'b0);
    run_text(" ", 1'b1);                     // empty document
    run_text(",", 1'b1);                     // comma with no container
    run_text("[}", 1'b0);
    run_text("]", 1'b0);
    run_text("{{", 1'b0);                    // container directly under object
    run_text("[\"q\\x", 1'b0);
    run_text("[tru", 1'b1);
  endtask

  task automatic test_pool_limit();
    set_limit(1);
    run_text("[1]", 1'b0);
    run_text("[[", 1'b0);
    set_limit(2);
    run_text("{\"a\":1}", 1'b0);
    set_limit(64);
    // fill the pool and saturate the child count
    doc_q.push_back(CH_LBRACK);
    repeat (64) push_text("1,");
    send_doc(1'b1);
  endtask

  task automatic test_random_docs();
    int limits[7] = '{1, 2, 3, 5, 8, 64, 0};
    int docs;
    int v;
    int d;
    docs = 0;
    while (sent_bytes < 300) begin
      if (docs % 8 == 7) begin
        v = limits[$urandom_range(0, 6)];
        set_limit(v == 0 ? $urandom_range(1, 64) : v);
      end
      gen_value(0);
      if (doc_q[0] != CH_LBRACK && doc_q[0] != CH_LBRACE) doc_q.push_front(CH_LBRACK);
      d = $urandom_range(0, 9);
      if (d == 0) doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (d == 1 && doc_q.size() > 1)
        doc_q = doc_q[0:$urandom_range(0, doc_q.size() - 2)];
      else if (d == 2) doc_q.push_back(CH_NUL);
      send_doc($urandom_range(0, 2) == 0);
      // trailing noise after the document, closed or not
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
        foreach (doc_q[i]) send_byte('{data_byte: doc_q[i], doc_start: 1'b0,
                                      end_of_input: 1'(($urandom_range(0, 1)))});
        doc_q.delete();
      end
      docs++;
    end
  endtask

  initial begin
    clear_doc();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_docs();
    test_pool_limit();
    test_random_docs();
    wait_quiet();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/jst_pkg.sv
hdl/json_strict_tokenizer.sv
sim/tb_top.sv
